// ===== rtl/sit_pkg.sv =====
// ----------------------------------------------------------------------------
// sit_pkg: shared types and constants of the sorted id offset table
// field widths, request and status codes, register indexes, sequencer states
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int MAX_ENTRIES_DEF   = 1024;
    localparam int TEXT_CAPACITY_DEF = 65536;

    localparam int OP_W      = 2;
    localparam int ID_W      = 32;
    localparam int KEY_W     = 31;
    localparam int LEN_W     = 16;
    localparam int ST_W      = 2;
    localparam int OFF_W     = 16;
    localparam int POS_W     = 11;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS   = 2'd1;
    localparam logic [ST_W-1:0] ST_REJECT = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LANG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX  = 2'd2;

    localparam logic [CFG_W-1:0] MAX_ID_RESET = 31'd65535;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMAX,
        S_CMIN,
        S_CCAP,
        S_SRCH,
        S_CMP,
        S_HCHK,
        S_DEC,
        S_SHRD,
        S_SHWR,
        S_INS,
        S_RESP
    } t_state;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

endpackage

// ===== rtl/sit_ram.sv =====
// ----------------------------------------------------------------------------
// sit_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module sit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sit_cmp.sv =====
// ----------------------------------------------------------------------------
// sit_cmp: shared magnitude comparator
// gives a < b and a == b for the range, capacity and search checks
// ----------------------------------------------------------------------------
module sit_cmp #(
    parameter int WIDTH = 31
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output sit_pkg::t_cmp    o_res
);

    logic [WIDTH:0] w_diff;

    // borrow out of a - b means a < b
    assign w_diff    = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.lt  = w_diff[WIDTH];
    assign o_res.eq  = (w_diff == '0);

endmodule

// ===== rtl/sorted_id_offset_table_top.sv =====
// ----------------------------------------------------------------------------
// sorted_id_offset_table_top: sorted id table with binary search and insert
// keeps ids ascending with a text offset each, bump-allocates text space
// ----------------------------------------------------------------------------
// One item is handled at a time by a sequencer around a single comparator and
// one ram holding id and offset per entry. Each binary search step reads the
// ram, then compares. An insert adds two checks (minimum id and text space),
// a write, and a read and a write for every entry shifted up by one. Clear and
// items rejected on arrival go straight to the response state; an id range or
// text store reject goes there after the failing check. A finished result sits
// in an output register, so the next item is taken while it waits. The table
// needs no clearing pass after reset: only entries below the entry count are
// read.
// ----------------------------------------------------------------------------
module sorted_id_offset_table_top #(
    parameter int MAX_ENTRIES   = sit_pkg::MAX_ENTRIES_DEF,
    parameter int TEXT_CAPACITY = sit_pkg::TEXT_CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sit_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sit_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [sit_pkg::OP_W-1:0]          i_operation,
    input  logic signed [sit_pkg::ID_W-1:0]   i_text_id,
    input  logic [sit_pkg::LEN_W-1:0]         i_text_length,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [sit_pkg::ST_W-1:0]          o_status,
    output logic [sit_pkg::OFF_W-1:0]         o_text_offset,
    output logic [sit_pkg::POS_W-1:0]         o_entry_position
);

    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int AAW   = $clog2(MAX_ENTRIES);
    localparam int NFW   = $clog2(TEXT_CAPACITY);
    localparam int SUMW  = ((NFW > sit_pkg::LEN_W) ? NFW : sit_pkg::LEN_W) + 1;
    localparam int KW    = sit_pkg::KEY_W;
    localparam int CMPW  = (SUMW > KW) ? SUMW : KW;
    localparam int EW    = KW + NFW;

    sit_pkg::t_state r_state, n_state;

    logic                          r_lang;
    logic [sit_pkg::CFG_W-1:0]     r_min;
    logic [sit_pkg::CFG_W-1:0]     r_max;
    logic [CW-1:0]                 r_count, n_count;
    logic [NFW-1:0]                r_free, n_free;

    logic [sit_pkg::OP_W-1:0]      r_op, n_op;
    logic [KW-1:0]                 r_key, n_key;
    logic [SUMW-1:0]               r_sum, n_sum;
    logic [CW-1:0]                 r_lo, n_lo;
    logic [CW-1:0]                 r_hi, n_hi;
    logic [CW-1:0]                 r_i, n_i;
    logic                          r_hit, n_hit;
    logic [NFW-1:0]                r_off, n_off;
    logic [sit_pkg::ST_W-1:0]      r_rst, n_rst;
    logic [sit_pkg::OFF_W-1:0]     r_roff, n_roff;
    logic [sit_pkg::POS_W-1:0]     r_rpos, n_rpos;

    logic                          r_ovalid, n_ovalid;
    logic [sit_pkg::ST_W-1:0]      r_ost, n_ost;
    logic [sit_pkg::OFF_W-1:0]     r_ooff, n_ooff;
    logic [sit_pkg::POS_W-1:0]     r_opos, n_opos;

    logic [CW:0]                   w_mid_sum;
    logic [CW-1:0]                 w_mid;
    logic [CW-1:0]                 w_mid_inc;
    logic [CW-1:0]                 w_i_dec;
    logic                          w_lo_lt_hi;
    logic                          w_lo_lt_cnt;
    logic                          w_full;
    logic                          w_neg;
    logic                          w_op_known;
    logic                          w_reject;
    logic                          w_take;

    logic [CMPW-1:0]               w_cmp_a, w_cmp_b;
    sit_pkg::t_cmp                 w_cmp;

    logic                          w_we;
    logic [AAW-1:0]                w_waddr, w_raddr;
    logic [EW-1:0]                 w_wdata, w_rdata;
    logic [KW-1:0]                 w_rd_id;
    logic [NFW-1:0]                w_rd_off;

    sit_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    sit_cmp #(
        .WIDTH (CMPW)
    ) u_cmp (
        .i_a   (w_cmp_a),
        .i_b   (w_cmp_b),
        .o_res (w_cmp)
    );

    assign w_rd_id  = w_rdata[EW-1 -: KW];
    assign w_rd_off = w_rdata[NFW-1:0];

    assign w_mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid       = w_mid_sum[CW:1];
    assign w_mid_inc   = w_mid + CW'(1);
    assign w_i_dec     = r_i - CW'(1);
    assign w_lo_lt_hi  = (r_lo < r_hi);
    assign w_lo_lt_cnt = (r_lo < r_count);
    assign w_full      = (r_count == CW'(MAX_ENTRIES));

    assign w_neg      = i_text_id[sit_pkg::ID_W-1];
    assign w_op_known = (i_operation == sit_pkg::OP_LOOKUP) ||
                        (i_operation == sit_pkg::OP_INSERT) ||
                        (i_operation == sit_pkg::OP_CLEAR);
    // cheap rejects decided as the item is taken
    assign w_reject   = !r_lang || !w_op_known ||
                        (i_operation != sit_pkg::OP_CLEAR && w_neg) ||
                        (i_operation == sit_pkg::OP_INSERT && i_text_length == '0);
    assign w_take     = (r_state == sit_pkg::S_RESP) && (!r_ovalid || i_ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sit_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (w_reject || i_operation == sit_pkg::OP_CLEAR) begin
                        n_state = sit_pkg::S_RESP;
                    end else begin
                        n_state = sit_pkg::S_CMAX;
                    end
                end
            end
            sit_pkg::S_CMAX: begin
                if (w_cmp.lt) begin
                    n_state = sit_pkg::S_RESP;
                end else if (r_op == sit_pkg::OP_INSERT) begin
                    n_state = sit_pkg::S_CMIN;
                end else begin
                    n_state = sit_pkg::S_SRCH;
                end
            end
            sit_pkg::S_CMIN: begin
                n_state = w_cmp.lt ? sit_pkg::S_RESP : sit_pkg::S_CCAP;
            end
            sit_pkg::S_CCAP: begin
                n_state = w_cmp.lt ? sit_pkg::S_RESP : sit_pkg::S_SRCH;
            end
            sit_pkg::S_SRCH: begin
                if (w_lo_lt_hi) begin
                    n_state = sit_pkg::S_CMP;
                end else if (w_lo_lt_cnt) begin
                    n_state = sit_pkg::S_HCHK;
                end else begin
                    n_state = sit_pkg::S_DEC;
                end
            end
            sit_pkg::S_CMP: begin
                n_state = sit_pkg::S_SRCH;
            end
            sit_pkg::S_HCHK: begin
                n_state = sit_pkg::S_DEC;
            end
            sit_pkg::S_DEC: begin
                if (r_op != sit_pkg::OP_INSERT) begin
                    n_state = sit_pkg::S_RESP;
                end else if (r_hit) begin
                    n_state = sit_pkg::S_INS;
                end else if (w_full) begin
                    n_state = sit_pkg::S_RESP;
                end else if (w_lo_lt_cnt) begin
                    n_state = sit_pkg::S_SHRD;
                end else begin
                    n_state = sit_pkg::S_INS;
                end
            end
            sit_pkg::S_SHRD: begin
                n_state = sit_pkg::S_SHWR;
            end
            sit_pkg::S_SHWR: begin
                n_state = (w_i_dec > r_lo) ? sit_pkg::S_SHRD : sit_pkg::S_INS;
            end
            sit_pkg::S_INS: begin
                n_state = sit_pkg::S_RESP;
            end
            sit_pkg::S_RESP: begin
                if (w_take) begin
                    n_state = sit_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sit_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs of the sequencer
    always_comb begin
        n_count  = r_count;
        n_free   = r_free;
        n_op     = r_op;
        n_key    = r_key;
        n_sum    = r_sum;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_i      = r_i;
        n_hit    = r_hit;
        n_off    = r_off;
        n_rst    = r_rst;
        n_roff   = r_roff;
        n_rpos   = r_rpos;
        n_ovalid = r_ovalid && !i_ready;
        n_ost    = r_ost;
        n_ooff   = r_ooff;
        n_opos   = r_opos;
        w_cmp_a  = CMPW'(r_key);
        w_cmp_b  = CMPW'(r_key);
        w_we     = 1'b0;
        w_waddr  = r_lo[AAW-1:0];
        w_wdata  = {r_key, r_free};
        w_raddr  = w_mid[AAW-1:0];
        o_ready  = 1'b0;
        unique case (r_state)
            sit_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op   = i_operation;
                    n_key  = i_text_id[KW-1:0];
                    n_sum  = SUMW'(r_free) + SUMW'(i_text_length) + SUMW'(1);
                    n_lo   = '0;
                    n_hi   = r_count;
                    n_hit  = 1'b0;
                    n_rst  = sit_pkg::ST_REJECT;
                    n_roff = '0;
                    n_rpos = '0;
                    if (!w_reject && i_operation == sit_pkg::OP_CLEAR) begin
                        n_count = '0;
                        n_free  = '0;
                        n_rst   = sit_pkg::ST_DONE;
                    end
                end
            end
            sit_pkg::S_CMAX: begin
                // max < key rejects
                w_cmp_a = CMPW'(r_max);
                w_cmp_b = CMPW'(r_key);
            end
            sit_pkg::S_CMIN: begin
                w_cmp_a = CMPW'(r_key);
                w_cmp_b = CMPW'(r_min);
            end
            sit_pkg::S_CCAP: begin
                w_cmp_a = CMPW'(TEXT_CAPACITY - 1);
                w_cmp_b = CMPW'(r_sum);
                if (w_cmp.lt) begin
                    n_rst = sit_pkg::ST_FULL;
                end
            end
            sit_pkg::S_SRCH: begin
                w_raddr = w_lo_lt_hi ? w_mid[AAW-1:0] : r_lo[AAW-1:0];
            end
            sit_pkg::S_CMP: begin
                w_cmp_a = CMPW'(w_rd_id);
                w_cmp_b = CMPW'(r_key);
                if (w_cmp.lt) begin
                    n_lo = w_mid_inc;
                end else begin
                    n_hi = w_mid;
                end
            end
            sit_pkg::S_HCHK: begin
                w_cmp_a = CMPW'(w_rd_id);
                w_cmp_b = CMPW'(r_key);
                n_hit   = w_cmp.eq;
                n_off   = w_rd_off;
            end
            sit_pkg::S_DEC: begin
                n_rpos = sit_pkg::POS_W'(r_lo);
                if (r_op != sit_pkg::OP_INSERT) begin
                    n_rst  = r_hit ? sit_pkg::ST_DONE : sit_pkg::ST_MISS;
                    n_roff = r_hit ? sit_pkg::OFF_W'(r_off) : '0;
                end else if (!r_hit && w_full) begin
                    n_rst  = sit_pkg::ST_FULL;
                    n_roff = '0;
                end
                n_i = r_count;
            end
            sit_pkg::S_SHRD: begin
                w_raddr = w_i_dec[AAW-1:0];
            end
            sit_pkg::S_SHWR: begin
                // move entry i-1 up to i
                w_we    = 1'b1;
                w_waddr = r_i[AAW-1:0];
                w_wdata = w_rdata;
                n_i     = w_i_dec;
            end
            sit_pkg::S_INS: begin
                w_we    = 1'b1;
                w_waddr = r_lo[AAW-1:0];
                w_wdata = {r_key, r_free};
                if (!r_hit) begin
                    n_count = r_count + CW'(1);
                end
                n_free = r_sum[NFW-1:0];
                n_rst  = sit_pkg::ST_DONE;
                n_roff = sit_pkg::OFF_W'(r_free);
                n_rpos = sit_pkg::POS_W'(r_lo);
            end
            sit_pkg::S_RESP: begin
                if (w_take) begin
                    n_ovalid = 1'b1;
                    n_ost    = r_rst;
                    n_ooff   = r_roff;
                    n_opos   = r_rpos;
                end
            end
            default: begin
                n_ovalid = r_ovalid && !i_ready;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sit_pkg::S_IDLE;
            r_lang   <= 1'b0;
            r_min    <= '0;
            r_max    <= sit_pkg::MAX_ID_RESET;
            r_count  <= '0;
            r_free   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_free   <= n_free;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sit_pkg::CFG_LANG: r_lang <= i_cfg_data[0];
                    sit_pkg::CFG_MIN:  r_min  <= i_cfg_data;
                    sit_pkg::CFG_MAX:  r_max  <= i_cfg_data;
                    default: begin
                        r_lang <= r_lang;
                    end
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_key  <= n_key;
        r_sum  <= n_sum;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_i    <= n_i;
        r_hit  <= n_hit;
        r_off  <= n_off;
        r_rst  <= n_rst;
        r_roff <= n_roff;
        r_rpos <= n_rpos;
        r_ost  <= n_ost;
        r_ooff <= n_ooff;
        r_opos <= n_opos;
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_ost;
    assign o_text_offset    = r_ooff;
    assign o_entry_position = r_opos;

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the sorted id offset table
// drives lookup, insert and clear items through a valid/ready channel with
// random gaps and stalls, keeps its own copy of the sorted table and the text
// allocator to work out each result, and compares every result field by field
// ----------------------------------------------------------------------------
module tb_top;
    import sit_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
    localparam int              ENTRY_LIMIT = MAX_ENTRIES_DEF;
    localparam int              STORE_SIZE  = TEXT_CAPACITY_DEF;
    localparam int              CYCLE_LIMIT = 20_000_000;

    typedef struct {
        logic [ST_W-1:0]  status;
        logic [OFF_W-1:0] offset;
        logic [POS_W-1:0] position;
    } t_answer;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx     = CFG_LANG;
    logic [CFG_W-1:0]        i_cfg_data    = '0;
    logic                    i_valid       = 1'b0;
    logic                    o_ready;
    logic [OP_W-1:0]         i_operation   = OP_LOOKUP;
    logic signed [ID_W-1:0]  i_text_id     = '0;
    logic [LEN_W-1:0]        i_text_length = '0;
    logic                    o_valid;
    logic                    i_ready       = 1'b1;
    logic [ST_W-1:0]         o_status;
    logic [OFF_W-1:0]        o_text_offset;
    logic [POS_W-1:0]        o_entry_position;

    // own copy of the table, the allocator and the registers
    logic [ID_W-1:0]  tbl_ids  [ENTRY_LIMIT];
    logic [OFF_W-1:0] tbl_offs [ENTRY_LIMIT];
    int               n_entries = 0;
    int               free_ptr  = 0;
    logic             lang_on   = 1'b0;
    logic [CFG_W-1:0] min_id    = '0;
    logic [CFG_W-1:0] max_id    = MAX_ID_RESET;

    t_answer     answers_due[$];
    int          error_count  = 0;
    int          result_count = 0;
    bit          no_idle      = 1'b0;
    int          rx_wait      = 0;
    int unsigned cycle_cnt    = 0;

    sorted_id_offset_table_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_text_id        (i_text_id),
        .i_text_length    (i_text_length),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_text_offset    (o_text_offset),
        .o_entry_position (o_entry_position)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 9);
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    // lowest position whose id is not below key
    function automatic int find_slot(input logic [ID_W-1:0] key, output bit hit);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = n_entries;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (tbl_ids[mid] < key) lo = mid + 1;
            else hi = mid;
        end
        hit = (lo < n_entries) && (tbl_ids[lo] == key);
        return lo;
    endfunction

    function automatic t_answer table_predict(input logic [OP_W-1:0] op,
                                              input logic [ID_W-1:0] id,
                                              input logic [LEN_W-1:0] len);
        t_answer a;
        int      slot;
        bit      hit;
        a.status   = ST_REJECT;
        a.offset   = '0;
        a.position = '0;
        if (!lang_on || op == OP_UNUSED) return a;
        if (op == OP_CLEAR) begin
            n_entries = 0;
            free_ptr  = 0;
            a.status  = ST_DONE;
            return a;
        end
        if (op == OP_LOOKUP) begin
            if (id[ID_W-1] || id > {1'b0, max_id}) return a;
            slot = find_slot(id, hit);
            if (hit) begin
                a.status = ST_DONE;
                a.offset = tbl_offs[slot];
            end else begin
                a.status = ST_MISS;
            end
            a.position = slot[POS_W-1:0];
            return a;
        end
        if (id[ID_W-1] || id < {1'b0, min_id} || id > {1'b0, max_id} || len == 0) return a;
        if (free_ptr + int'(len) + 1 > STORE_SIZE - 1) begin
            a.status = ST_FULL;
            return a;
        end
        slot = find_slot(id, hit);
        if (!hit) begin
            if (n_entries >= ENTRY_LIMIT) begin
                a.status   = ST_FULL;
                a.position = slot[POS_W-1:0];
                return a;
            end
            for (int i = n_entries; i > slot; i--) begin
                tbl_ids[i]  = tbl_ids[i-1];
                tbl_offs[i] = tbl_offs[i-1];
            end
            n_entries++;
        end
        // a known id just gets the new offset, old space is not reclaimed
        tbl_ids[slot]  = id;
        tbl_offs[slot] = free_ptr[OFF_W-1:0];
        a.status       = ST_DONE;
        a.offset       = free_ptr[OFF_W-1:0];
        a.position     = slot[POS_W-1:0];
        free_ptr       = free_ptr + int'(len) + 1;
        return a;
    endfunction

    // receiver: random stall after each accepted result
    always @(posedge i_clk) begin : result_sink
        int stall;
        if (!i_rst_n) begin
            i_ready <= 1'b1;
            rx_wait <= 0;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            if (rx_wait == 1) i_ready <= 1'b1;
        end else if (o_valid === 1'b1 && i_ready) begin
            stall = draw_gap();
            if (stall > 0) begin
                i_ready <= 1'b0;
                rx_wait <= stall;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_answer want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready) begin
            result_count++;
            if (answers_due.size() == 0) begin
                flag_error($sformatf("result %0d arrived with none expected", result_count));
            end else begin
                want = answers_due.pop_front();
                if (o_status !== want.status)
                    flag_error($sformatf("result %0d status: expected %0d, got %0d",
                                         result_count, want.status, o_status));
                if (o_text_offset !== want.offset)
                    flag_error($sformatf("result %0d text_offset: expected %0d, got %0d",
                                         result_count, want.offset, o_text_offset));
                if (o_entry_position !== want.position)
                    flag_error($sformatf("result %0d entry_position: expected %0d, got %0d",
                                         result_count, want.position, o_entry_position));
            end
        end
    end

    task automatic issue_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                 input logic [LEN_W-1:0] len);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_text_id     <= id;
        i_text_length <= len;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        answers_due.push_back(table_predict(op, id, len));
    endtask

    task automatic wait_until_idle;
        i_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_LANG: lang_on = data[0];
            CFG_MIN:  min_id  = data;
            CFG_MAX:  max_id  = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // only bit 0 of the language register counts
    task automatic set_language(input logic on);
        logic [CFG_W-1:0] data;
        data = CFG_W'($urandom & 32'h7FFF_FFFE) | CFG_W'(on);
        write_reg(CFG_LANG, data);
    endtask

    task automatic test_without_language;
        issue_request(OP_LOOKUP, 32'd0, 16'd0);
        issue_request(OP_INSERT, 32'd5, 16'd3);
        issue_request(OP_CLEAR, 32'd0, 16'd0);
        issue_request(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
        wait_until_idle();
        set_language(1'b1);
    endtask

    task automatic test_directed;
        issue_request(OP_LOOKUP, 32'd0, 16'd0);
        issue_request(OP_INSERT, 32'd100, 16'd0);
        issue_request(OP_INSERT, 32'd65536, 16'd4);
        issue_request(OP_LOOKUP, 32'hFFFF_FFFF, 16'd0);
        issue_request(OP_LOOKUP, 32'd65536, 16'd0);
        issue_request(OP_INSERT, 32'd100, 16'd5);
        issue_request(OP_INSERT, 32'd50, 16'd1);
        issue_request(OP_INSERT, 32'd65535, 16'd10);
        issue_request(OP_INSERT, 32'd0, 16'd1);
        issue_request(OP_LOOKUP, 32'd100, 16'd0);
        issue_request(OP_LOOKUP, 32'd75, 16'd0);
        issue_request(OP_LOOKUP, 32'd65535, 16'd0);
        issue_request(OP_LOOKUP, 32'd0, 16'd0);
        issue_request(OP_INSERT, 32'd100, 16'd3);
        issue_request(OP_LOOKUP, 32'd100, 16'd0);
        issue_request(OP_UNUSED, 32'd100, 16'd1);
        issue_request(OP_INSERT, 32'd200, 16'hFFFF);
        issue_request(OP_CLEAR, 32'd0, 16'd0);
        // exact fill of the text store, then one more
        issue_request(OP_INSERT, 32'd7, 16'd65534);
        issue_request(OP_INSERT, 32'd8, 16'd1);
        issue_request(OP_LOOKUP, 32'd7, 16'd0);
        issue_request(OP_CLEAR, 32'd0, 16'd0);
    endtask

    task automatic test_id_limits;
        wait_until_idle();
        write_reg(CFG_MIN, 31'd1000);
        write_reg(CFG_MAX, 31'd2000);
        issue_request(OP_INSERT, 32'd999, 16'd2);
        issue_request(OP_INSERT, 32'd1000, 16'd2);
        issue_request(OP_INSERT, 32'd2000, 16'd2);
        issue_request(OP_INSERT, 32'd2001, 16'd2);
        issue_request(OP_LOOKUP, 32'd2001, 16'd0);
        issue_request(OP_LOOKUP, 32'd999, 16'd0);
        wait_until_idle();
        write_reg(CFG_MIN, 31'h7FFF_FFFF);
        write_reg(CFG_MAX, 31'h7FFF_FFFF);
        issue_request(OP_INSERT, 32'h7FFF_FFFF, 16'd1);
        issue_request(OP_LOOKUP, 32'h7FFF_FFFF, 16'd0);
        issue_request(OP_LOOKUP, 32'h8000_0000, 16'd0);
        wait_until_idle();
        set_language(1'b0);
        issue_request(OP_CLEAR, 32'd0, 16'd0);
        issue_request(OP_LOOKUP, 32'h7FFF_FFFF, 16'd0);
        wait_until_idle();
        set_language(1'b1);
    endtask

    // fill every entry, one insert shifting the whole table, then hit the full case
    task automatic test_table_full;
        logic [ID_W-1:0] key;
        wait_until_idle();
        write_reg(CFG_MIN, 31'd0);
        write_reg(CFG_MAX, 31'h7FFF_FFFF);
        issue_request(OP_CLEAR, 32'd0, 16'd0);
        key = $urandom_range(1, 1000);
        for (int i = 0; i < ENTRY_LIMIT - 1; i++) begin
            issue_request(OP_INSERT, key, 16'($urandom_range(1, 20)));
            key = key + $urandom_range(1, 1_000_000);
        end
        issue_request(OP_INSERT, 32'd0, 16'd1);
        issue_request(OP_INSERT, key, 16'd1);
        issue_request(OP_INSERT, tbl_ids[700] + 32'd1, 16'd1);
        issue_request(OP_INSERT, tbl_ids[700], 16'd3);
        issue_request(OP_INSERT, 32'd0, 16'd2);
        issue_request(OP_LOOKUP, key, 16'd0);
        issue_request(OP_LOOKUP, tbl_ids[ENTRY_LIMIT-1], 16'd0);
        issue_request(OP_LOOKUP, 32'd0, 16'd0);
        for (int i = 0; i < 10; i++)
            issue_request(OP_LOOKUP, tbl_ids[$urandom_range(0, ENTRY_LIMIT - 1)], 16'd0);
        issue_request(OP_CLEAR, 32'd0, 16'd0);
    endtask

    // mostly ids near the accepted range or already stored, some noise
    function automatic logic [ID_W-1:0] pick_id();
        logic [ID_W-1:0] lo;
        logic [ID_W-1:0] top;
        logic [ID_W-1:0] hi;
        lo  = (min_id <= max_id) ? {1'b0, min_id} : {1'b0, max_id};
        top = (min_id <= max_id) ? {1'b0, max_id} : {1'b0, min_id};
        hi  = (lo + 200 < top) ? lo + 200 : top;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                if (n_entries > 0) return tbl_ids[$urandom_range(0, n_entries - 1)];
                return $urandom_range(hi, lo);
            end
            4, 5, 6: return $urandom_range(hi, lo);
            7: begin
                case ($urandom_range(0, 3))
                    0: return {1'b0, min_id} - 32'd1;
                    1: return {1'b0, min_id};
                    2: return {1'b0, max_id};
                    default: return {1'b0, max_id} + 32'd1;
                endcase
            end
            8: return $urandom | 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return LEN_W'($urandom_range(0, 65535));
            2: return LEN_W'($urandom_range(1000, 8000));
            default: return LEN_W'($urandom_range(1, 64));
        endcase
    endfunction

    task automatic issue_random;
        int              r;
        logic [OP_W-1:0] op;
        r = $urandom_range(0, 19);
        if (r < 8) op = OP_LOOKUP;
        else if (r == 17) op = OP_CLEAR;
        else if (r == 18) op = OP_UNUSED;
        else op = OP_INSERT;
        issue_request(op, pick_id(), pick_length());
    endtask

    task automatic test_random_traffic;
        logic [CFG_W-1:0] base;
        int               count;
        for (int ph = 0; ph < 7; ph++) begin
            wait_until_idle();
            base = CFG_W'($urandom_range(0, 5000));
            case (ph)
                0: begin
                    set_language(1'b1);
                    write_reg(CFG_MIN, 31'd0);
                    write_reg(CFG_MAX, 31'h7FFF_FFFF);
                end
                1: begin
                    write_reg(CFG_MIN, base);
                    write_reg(CFG_MAX, base);
                end
                2: begin
                    set_language(1'b0);
                    write_reg(CFG_MIN, base);
                    write_reg(CFG_MAX, CFG_W'(base + $urandom_range(0, 3000)));
                end
                3: begin
                    // min above max: no insert can pass
                    set_language(1'b1);
                    write_reg(CFG_MIN, CFG_W'(base + $urandom_range(1, 100)));
                    write_reg(CFG_MAX, base);
                end
                4: begin
                    write_reg(CFG_MIN, 31'd0);
                    write_reg(CFG_MAX, 31'd0);
                end
                5: begin
                    base = CFG_W'($urandom_range(0, 32'h7FFF_0000));
                    write_reg(CFG_MIN, base);
                    write_reg(CFG_MAX, CFG_W'(base + $urandom_range(0, 3000)));
                end
                default: begin
                    write_reg(CFG_MIN, 31'd0);
                    write_reg(CFG_MAX, MAX_ID_RESET);
                end
            endcase
            count = lang_on ? 72 : 20;
            for (int k = 0; k < count; k++) begin
                if (k % 24 == 0) no_idle = ($urandom_range(0, 3) == 0);
                issue_random();
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_without_language();
        test_directed();
        test_id_limits();
        test_table_full();
        test_random_traffic();
        wait_until_idle();
        repeat (60) @(posedge i_clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
